@@ rtl/line_pixel_generator_top_macros.svh @@
// Assertion macros used by the line pixel generator top level.
`ifndef LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTH
// Checked on every rising clock edge, reset included.
`define LPG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
// Checked only while the block is out of reset.
`define LPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define LPG_ASSERT_ALWAYS(name, prop, msg)
`define LPG_ASSERT(name, prop, msg)
`endif
`endif

@@ rtl/lpg_pkg.sv @@
// Package with the types and constants of the line pixel generator.
`timescale 1ns / 1ps
package lpg_pkg;

  localparam int unsigned GRID_W    = 7;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } lpg_cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } lpg_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } lpg_cmd_t;

  typedef struct packed {
    logic last;
  } lpg_sts_t;

endpackage

@@ rtl/lpg_ctrl.sv @@
// Controller state machine of the line pixel generator.
`timescale 1ns / 1ps
module lpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lpg_pkg::lpg_sts_t sts_i,
  output lpg_pkg::lpg_cmd_t cmd_o
);
  import lpg_pkg::*;

  lpg_state_e state_q, state_d;
  logic       finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    finish      = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        out_valid_o = 1'b1;
        finish      = out_ready_i && sts_i.last;
        // A new command is taken together with the last pixel of the current one.
        in_ready_o  = finish;
        cmd_o.load  = finish && in_valid_i;
        cmd_o.step  = out_ready_i && !sts_i.last;
        if (finish && !in_valid_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/lpg_dp.sv @@
// Datapath of the line pixel generator: setup, Bresenham step and grid registers.
`timescale 1ns / 1ps
module lpg_dp #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lpg_pkg::lpg_cmd_t                   cmd_i,
  output lpg_pkg::lpg_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lpg_pkg::GRID_W-1:0]          cfg_data_i,
  input  logic [COORD_BITS-1:0]               start_x_i,
  input  logic [COORD_BITS-1:0]               start_y_i,
  input  logic [COORD_BITS-1:0]               end_x_i,
  input  logic [COORD_BITS-1:0]               end_y_i,
  input  logic                                draw_enable_i,
  input  logic [lpg_pkg::COLOR_W-1:0]         color_red_i,
  input  logic [lpg_pkg::COLOR_W-1:0]         color_green_i,
  input  logic [lpg_pkg::COLOR_W-1:0]         color_blue_i,
  output logic [COORD_BITS-1:0]               pixel_x_o,
  output logic [COORD_BITS-1:0]               pixel_y_o,
  output logic                                in_bounds_o,
  output logic [lpg_pkg::COLOR_W-1:0]         out_red_o,
  output logic [lpg_pkg::COLOR_W-1:0]         out_green_o,
  output logic [lpg_pkg::COLOR_W-1:0]         out_blue_o,
  output logic                                last_pixel_o
);
  import lpg_pkg::*;

  localparam int unsigned ERR_W = COORD_BITS + 2;

  logic [GRID_W-1:0]     grid_w_q, grid_h_q;
  logic [COORD_BITS-1:0] x_q, y_q, x_d, y_d;
  logic [COORD_BITS-1:0] major_q, minor_q, cnt_q;
  logic [ERR_W-1:0]      err_q, err_d;
  logic                  xmajor_q, negx_q, negy_q;
  logic [COLOR_W-1:0]    red_q, green_q, blue_q;

  // Setup of a new line.
  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] adx, ady, major_n, minor_n;
  logic                  xmajor_n;
  logic [ERR_W-1:0]      err_n;

  // One step along the line.
  logic                  err_pos;
  logic [COORD_BITS-1:0] x_inc, y_inc;

  always_comb begin
    dx       = {1'b0, end_x_i} - {1'b0, start_x_i};
    dy       = {1'b0, end_y_i} - {1'b0, start_y_i};
    adx      = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady      = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    xmajor_n = adx >= ady;
    major_n  = xmajor_n ? adx : ady;
    minor_n  = xmajor_n ? ady : adx;
    err_n    = {2'b00, minor_n} - {3'b000, major_n[COORD_BITS-1:1]};
  end

  always_comb begin
    err_pos = !err_q[ERR_W-1] && (err_q != '0);
    x_inc   = negx_q ? x_q - 1'b1 : x_q + 1'b1;
    y_inc   = negy_q ? y_q - 1'b1 : y_q + 1'b1;
    x_d     = x_q;
    y_d     = y_q;
    if (xmajor_q) begin
      x_d = x_inc;
      if (err_pos) begin
        y_d = y_inc;
      end
    end else begin
      y_d = y_inc;
      if (err_pos) begin
        x_d = x_inc;
      end
    end
    err_d = err_q + {2'b00, minor_q} - (err_pos ? {2'b00, major_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_RESET;
      grid_h_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_w_q <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= start_x_i;
      y_q      <= start_y_i;
      err_q    <= err_n;
      major_q  <= major_n;
      minor_q  <= minor_n;
      cnt_q    <= major_n;
      xmajor_q <= xmajor_n;
      negx_q   <= dx[COORD_BITS];
      negy_q   <= dy[COORD_BITS];
      red_q    <= draw_enable_i ? color_red_i : '0;
      green_q  <= draw_enable_i ? color_green_i : '0;
      blue_q   <= draw_enable_i ? color_blue_i : '0;
    end else if (cmd_i.step) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign sts_o.last   = (cnt_q == '0);
  assign pixel_x_o    = x_q;
  assign pixel_y_o    = y_q;
  assign in_bounds_o  = (GRID_W'(x_q) < grid_w_q) && (GRID_W'(y_q) < grid_h_q);
  assign out_red_o    = red_q;
  assign out_green_o  = green_q;
  assign out_blue_o   = blue_q;
  assign last_pixel_o = sts_o.last;

endmodule

@@ rtl/line_pixel_generator_top.sv @@
// Top level of the line pixel generator: Bresenham rasterizer for one line command.
// First pixel: offered in the cycle after its command transfer.
// Throughput: one pixel per cycle while out_ready_i is high, |major| + 1 pixels per line
// (1 to 2^COORD_BITS), set by the single error-update step in the datapath; a new command
// transfers together with the last pixel of the line before, so lines follow without a gap.
// Reset: asynchronous and active low; idle, both grid sizes read 64.
`timescale 1ns / 1ps
`include "line_pixel_generator_top_macros.svh"
module line_pixel_generator_top #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lpg_pkg::GRID_W-1:0]    cfg_data_i,
  // Line command channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS-1:0]         start_x_i,
  input  logic [COORD_BITS-1:0]         start_y_i,
  input  logic [COORD_BITS-1:0]         end_x_i,
  input  logic [COORD_BITS-1:0]         end_y_i,
  input  logic                          draw_enable_i,
  input  logic [lpg_pkg::COLOR_W-1:0]   color_red_i,
  input  logic [lpg_pkg::COLOR_W-1:0]   color_green_i,
  input  logic [lpg_pkg::COLOR_W-1:0]   color_blue_i,
  // Pixel channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_BITS-1:0]         pixel_x_o,
  output logic [COORD_BITS-1:0]         pixel_y_o,
  output logic                          in_bounds_o,
  output logic [lpg_pkg::COLOR_W-1:0]   out_red_o,
  output logic [lpg_pkg::COLOR_W-1:0]   out_green_o,
  output logic [lpg_pkg::COLOR_W-1:0]   out_blue_o,
  output logic                          last_pixel_o
);
  import lpg_pkg::*;

  // The controller only sequences; all coordinates, the error term and the
  // pixel counter live in the datapath, which reports when the pixel on
  // display is the end point.
  lpg_cmd_t cmd;
  lpg_sts_t sts;

  lpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath registers are the output register: a pixel stays on the
  // outputs until its transfer, then the next pixel is stepped in.
  lpg_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .draw_enable_i (draw_enable_i),
    .color_red_i   (color_red_i),
    .color_green_i (color_green_i),
    .color_blue_i  (color_blue_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .in_bounds_o   (in_bounds_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .last_pixel_o  (last_pixel_o)
  );

  // A command is only taken when no line is running or the running one ends now.
  `LPG_ASSERT_ALWAYS(a_ready_only_when_free, in_ready_o |-> (!out_valid_o || (out_ready_i && last_pixel_o)), "command taken while a line is still running")

  // A line keeps emitting until its last pixel has been transferred.
  `LPG_ASSERT(a_run_continues, (out_valid_o && out_ready_i && !last_pixel_o) |=> out_valid_o, "line ended before its last pixel")

  // Every step moves along the major axis, so consecutive pixels differ.
  `LPG_ASSERT(a_pixel_moves, (out_valid_o && out_ready_i && !last_pixel_o) |=> ((pixel_x_o != $past(pixel_x_o)) || (pixel_y_o != $past(pixel_y_o))), "pixel repeated within a line")

endmodule
